// ===== hdl/mff_pkg.sv =====
// Package for the maze flood-fill engine.
// Holds grid constants, opcode and direction codes, port structs and grid helper functions.
// Depends on nothing; the engine, cell store, queue and bench files import it.
package mff_pkg;

    localparam int GRID_SIDE = 16;
    localparam int CELLS = 256;
    localparam logic [7:0] LAST_CELL = 8'(CELLS - 1);
    localparam logic [7:0] UNREACHED = 8'd255;
    localparam logic [7:0] MAX_STEP = 8'd254;
    localparam logic [4:0] SIDE5 = 5'(GRID_SIDE);
    localparam logic [3:0] GOAL_LO = 4'(GRID_SIDE / 2 - 1);
    localparam logic [3:0] GOAL_HI = 4'(GRID_SIDE / 2);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FLOOD = 2'd1,
        OP_DIST  = 2'd2,
        OP_DIR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    typedef struct packed {
        logic       valid;
        logic [7:0] idx;
    } t_nbr;

    typedef struct packed {
        logic [7:0] rd_addr;
        logic       wall_we;
        logic [7:0] wall_wa;
        logic [3:0] wall_wd;
        logic       dist_we;
        logic [7:0] dist_wa;
        logic [7:0] dist_wd;
    } t_store_cmd;

    typedef struct packed {
        logic [3:0] wall;
        logic [7:0] cell_dist;
    } t_store_rsp;

    typedef struct packed {
        logic       clr;
        logic       push;
        logic [7:0] push_idx;
        logic       pop;
    } t_queue_cmd;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_idx;
    } t_queue_rsp;

    function automatic logic mff_in_grid(input logic [3:0] x, input logic [3:0] y);
        return ({1'b0, x} < SIDE5) && ({1'b0, y} < SIDE5);
    endfunction

    // Neighbor of a cell in one direction; valid is low when it leaves the grid.
    function automatic t_nbr mff_nbr(input logic [7:0] idx, input logic [1:0] d);
        t_nbr       r;
        logic [3:0] x;
        logic [3:0] y;
        x = idx[3:0];
        y = idx[7:4];
        r.valid = 1'b0;
        unique case (t_dir'(d))
            DIR_NORTH: begin
                r.valid = ({1'b0, y} + 5'd1) < SIDE5;
                y = y + 4'd1;
            end
            DIR_EAST: begin
                r.valid = ({1'b0, x} + 5'd1) < SIDE5;
                x = x + 4'd1;
            end
            DIR_SOUTH: begin
                r.valid = (y != 4'd0);
                y = y - 4'd1;
            end
            DIR_WEST: begin
                r.valid = (x != 4'd0);
                x = x - 4'd1;
            end
            default: begin
                r.valid = 1'b0;
            end
        endcase
        r.idx = {y, x};
        return r;
    endfunction

    // The four center goal cells in seeding order.
    function automatic logic [7:0] mff_goal_cell(input logic [1:0] i);
        logic [3:0] x;
        logic [3:0] y;
        x = i[1] ? GOAL_HI : GOAL_LO;
        y = i[0] ? GOAL_HI : GOAL_LO;
        return {y, x};
    endfunction

endpackage

// ===== hdl/mff_if.sv =====
// Handshake interfaces for the request and response channels of the flood-fill engine.
// Each carries valid, ready and the payload fields; no dependencies.
interface mff_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] wall_bits;
    logic [1:0] heading;

    modport source(output valid, output opcode, output cell_x, output cell_y,
                   output wall_bits, output heading, input ready);
    modport sink(input valid, input opcode, input cell_x, input cell_y,
                 input wall_bits, input heading, output ready);
endinterface

interface mff_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] distance;
    logic [1:0] move_dir;
    logic       flood_done;

    modport source(output valid, output distance, output move_dir, output flood_done,
                   input ready);
    modport sink(input valid, input distance, input move_dir, input flood_done,
                 output ready);
endinterface

// ===== hdl/maze_flood_fill_engine.sv =====
// Maze flood-fill engine top level: sequencer around the cell store and the visit queue.
// Writes, distance queries, direction queries and floods all end in the result register. Neighbor
// scans are paced by the single distance read port, which serves one neighbor per cycle. One item
// is in work at a time. After reset a clearing pass over all 256 cells zeroes the walls and sets
// every distance to 255; no transaction is accepted during it. Depends on mff_pkg, mff_if,
// mff_cell_store, mff_queue.
module maze_flood_fill_engine
    import mff_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mff_req_if.sink   i_req,
    mff_rsp_if.source o_rsp
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_QDIST,
        S_CLEAR,
        S_SEED,
        S_POP,
        S_CELL,
        S_LOAD,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic       r_flood, n_flood;
    logic [7:0] r_cur, n_cur;
    logic [3:0] r_walls, n_walls;
    logic [7:0] r_here, n_here;
    logic [2:0] r_d, n_d;
    logic       r_pv, n_pv;
    logic [7:0] r_pn, n_pn;
    logic [1:0] r_pd, n_pd;
    logic [7:0] r_best, n_best;
    logic [7:0] r_res_dist, n_res_dist;
    logic [1:0] r_res_dir, n_res_dir;
    logic       r_res_done, n_res_done;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_dist, n_out_dist;
    logic [1:0] r_out_dir, n_out_dir;
    logic       r_out_done, n_out_done;

    t_store_cmd st_cmd;
    t_store_rsp st_rsp;
    t_queue_cmd q_cmd;
    t_queue_rsp q_rsp;

    logic       accept;
    logic       out_free;
    logic [7:0] req_idx;
    logic       req_in_grid;
    logic [1:0] issue_dir;
    logic [3:0] issue_walls;
    t_nbr       nb;
    logic       issue_ok;
    logic [8:0] step_sum;
    logic [7:0] step_dist;

    mff_cell_store u_store (
        .i_clk (i_clk),
        .i_cmd (st_cmd),
        .o_rsp (st_rsp)
    );

    mff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_rsp   (q_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign req_idx     = {i_req.cell_y, i_req.cell_x};
    assign req_in_grid = mff_in_grid(i_req.cell_x, i_req.cell_y);

    assign issue_dir   = (r_state == S_LOAD) ? 2'd0 : r_d[1:0];
    assign issue_walls = (r_state == S_LOAD) ? st_rsp.wall : r_walls;
    assign nb          = mff_nbr(r_cur, issue_dir);
    assign issue_ok    = !issue_walls[issue_dir] && nb.valid;

    assign step_sum  = {1'b0, r_here} + 9'd1;
    assign step_dist = (step_sum < {1'b0, UNREACHED}) ? step_sum[7:0] : MAX_STEP;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_flood     = r_flood;
        n_cur       = r_cur;
        n_walls     = r_walls;
        n_here      = r_here;
        n_d         = r_d;
        n_pv        = r_pv;
        n_pn        = r_pn;
        n_pd        = r_pd;
        n_best      = r_best;
        n_res_dist  = r_res_dist;
        n_res_dir   = r_res_dir;
        n_res_done  = r_res_done;
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_dir   = r_out_dir;
        n_out_done  = r_out_done;

        st_cmd         = '0;
        st_cmd.rd_addr = r_cur;
        q_cmd          = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                st_cmd.wall_we = 1'b1;
                st_cmd.wall_wa = r_cnt;
                st_cmd.wall_wd = 4'd0;
                st_cmd.dist_we = 1'b1;
                st_cmd.dist_wa = r_cnt;
                st_cmd.dist_wd = UNREACHED;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    st_cmd.rd_addr = req_idx;
                    n_cur      = req_idx;
                    n_flood    = 1'b0;
                    n_best     = UNREACHED;
                    n_res_dist = 8'd0;
                    n_res_dir  = 2'd0;
                    n_res_done = 1'b0;
                    unique case (t_opcode'(i_req.opcode))
                        OP_WRITE: begin
                            st_cmd.wall_we = req_in_grid;
                            st_cmd.wall_wa = req_idx;
                            st_cmd.wall_wd = i_req.wall_bits;
                            n_state = S_RESULT;
                        end
                        OP_FLOOD: begin
                            n_flood    = 1'b1;
                            n_res_done = 1'b1;
                            n_cnt      = 8'd0;
                            n_state    = S_CLEAR;
                        end
                        OP_DIST: begin
                            if (req_in_grid) begin
                                n_state = S_QDIST;
                            end else begin
                                n_res_dist = UNREACHED;
                                n_state    = S_RESULT;
                            end
                        end
                        OP_DIR: begin
                            n_res_dir = i_req.heading;
                            if (req_in_grid) begin
                                n_state = S_LOAD;
                            end else begin
                                n_res_dist = UNREACHED;
                                n_state    = S_RESULT;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_QDIST: begin
                n_res_dist = st_rsp.cell_dist;
                n_state    = S_RESULT;
            end
            S_CLEAR: begin
                st_cmd.dist_we = 1'b1;
                st_cmd.dist_wa = r_cnt;
                st_cmd.dist_wd = UNREACHED;
                q_cmd.clr = 1'b1;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = 8'd0;
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                st_cmd.dist_we = 1'b1;
                st_cmd.dist_wa = mff_goal_cell(r_cnt[1:0]);
                st_cmd.dist_wd = 8'd0;
                q_cmd.push     = 1'b1;
                q_cmd.push_idx = mff_goal_cell(r_cnt[1:0]);
                n_cnt = r_cnt + 8'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (q_rsp.empty) begin
                    n_state = S_RESULT;
                end else begin
                    q_cmd.pop = 1'b1;
                    n_state   = S_CELL;
                end
            end
            S_CELL: begin
                st_cmd.rd_addr = q_rsp.head_idx;
                n_cur   = q_rsp.head_idx;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_walls = st_rsp.wall;
                n_here  = st_rsp.cell_dist;
                if (!r_flood) begin
                    n_res_dist = st_rsp.cell_dist;
                end
                st_cmd.rd_addr = nb.idx;
                n_pv    = issue_ok;
                n_pn    = nb.idx;
                n_pd    = issue_dir;
                n_d     = 3'd1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_pv) begin
                    if (r_flood) begin
                        if (st_rsp.cell_dist == UNREACHED) begin
                            st_cmd.dist_we = 1'b1;
                            st_cmd.dist_wa = r_pn;
                            st_cmd.dist_wd = step_dist;
                            q_cmd.push     = !q_rsp.full;
                            q_cmd.push_idx = r_pn;
                        end
                    end else if (st_rsp.cell_dist < r_best) begin
                        n_best    = st_rsp.cell_dist;
                        n_res_dir = r_pd;
                    end
                end
                if (r_d == 3'd4) begin
                    n_pv    = 1'b0;
                    n_state = r_flood ? S_POP : S_RESULT;
                end else begin
                    st_cmd.rd_addr = nb.idx;
                    n_pv = issue_ok;
                    n_pn = nb.idx;
                    n_pd = issue_dir;
                    n_d  = r_d + 3'd1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_res_dist;
                    n_out_dir   = r_res_dir;
                    n_out_done  = r_res_done;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_flood     <= 1'b0;
            r_d         <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_flood     <= n_flood;
            r_d         <= n_d;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_walls     <= n_walls;
            r_here      <= n_here;
            r_pn        <= n_pn;
            r_pd        <= n_pd;
            r_best      <= n_best;
            r_res_dist  <= n_res_dist;
            r_res_dir   <= n_res_dir;
            r_res_done  <= n_res_done;
            r_out_dist  <= n_out_dist;
            r_out_dir   <= n_out_dir;
            r_out_done  <= n_out_done;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.distance   = r_out_dist;
    assign o_rsp.move_dir   = r_out_dir;
    assign o_rsp.flood_done = r_out_done;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cmd.push |-> !q_rsp.full)
        else $error("Visit queue pushed while full.");

    a_scan_no_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_cmd.dist_we && (r_state == S_SCAN)) |-> (st_cmd.rd_addr != st_cmd.dist_wa))
        else $error("Distance read and write hit the same cell during a scan.");

    a_flood_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.flood_done) |-> (o_rsp.distance == 8'd0 && o_rsp.move_dir == 2'd0))
        else $error("Flood result carries query data.");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("Result was not loaded into the output register.");

endmodule

// ===== hdl/mff_cell_store.sv =====
// Per-cell wall and distance memories, one write port each and a shared read address.
// Read data is registered and appears in the cycle after the address. Depends on mff_pkg.
module mff_cell_store
    import mff_pkg::*;
(
    input  logic       i_clk,
    input  t_store_cmd i_cmd,
    output t_store_rsp o_rsp
);

    logic [3:0] r_wall_mem [CELLS];
    logic [7:0] r_dist_mem [CELLS];
    logic [3:0] r_wall_q;
    logic [7:0] r_dist_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wall_we) begin
            r_wall_mem[i_cmd.wall_wa] <= i_cmd.wall_wd;
        end
        r_wall_q <= r_wall_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_we) begin
            r_dist_mem[i_cmd.dist_wa] <= i_cmd.dist_wd;
        end
        r_dist_q <= r_dist_mem[i_cmd.rd_addr];
    end

    assign o_rsp.wall      = r_wall_q;
    assign o_rsp.cell_dist = r_dist_q;

endmodule

// ===== hdl/mff_queue.sv =====
// Visit queue for the breadth-first walk: a cell-index memory with head and tail pointers.
// The popped entry is registered and shows on head_idx in the cycle after the pop. Depends on mff_pkg.
module mff_queue
    import mff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_cmd i_cmd,
    output t_queue_rsp o_rsp
);

    logic [7:0] r_mem [CELLS];
    logic [8:0] r_head;
    logic [8:0] r_tail;
    logic [7:0] r_head_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.clr) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_cmd.push && !r_tail[8]) begin
                r_tail <= r_tail + 9'd1;
            end
            if (i_cmd.pop) begin
                r_head <= r_head + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !r_tail[8]) begin
            r_mem[r_tail[7:0]] <= i_cmd.push_idx;
        end
        r_head_q <= r_mem[r_head[7:0]];
    end

    assign o_rsp.empty    = (r_head == r_tail);
    assign o_rsp.full     = r_tail[8];
    assign o_rsp.head_idx = r_head_q;

endmodule

// ===== bench/flood_checker.sv =====
`timescale 1ns / 1ps
// Checker for the maze flood-fill engine: watches the request and response channels,
// keeps its own wall and distance maps, predicts each reply and compares it field by field.
// Depends on mff_pkg and the handshake interfaces in mff_if.
module flood_checker
    import mff_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mff_req_if    i_req,
    mff_rsp_if    i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [7:0] distance;
        t_dir       move_dir;
        logic       flood_done;
    } t_reply;

    logic [3:0] wall_map [CELLS];
    logic [7:0] step_map [CELLS];
    t_reply     expected_replies [$];
    int         fail_total;

    function automatic bit on_grid(input int x, input int y);
        return (x < GRID_SIDE) && (y < GRID_SIDE);
    endfunction

    function automatic bit neighbor_cell(input logic [7:0] idx, input logic [1:0] d,
                                         output logic [7:0] nidx);
        int x;
        int y;
        x = int'(idx[3:0]);
        y = int'(idx[7:4]);
        case (t_dir'(d))
            DIR_NORTH: y = y + 1;
            DIR_EAST:  x = x + 1;
            DIR_SOUTH: y = y - 1;
            default:   x = x - 1;
        endcase
        nidx = {y[3:0], x[3:0]};
        return (x >= 0) && (y >= 0) && on_grid(x, y);
    endfunction

    function automatic void redo_distances();
        logic [7:0] visit [CELLS];
        int         head;
        int         tail;
        logic [7:0] cur;
        logic [7:0] nb;
        logic [7:0] nxt;
        bit         open;
        foreach (step_map[i]) step_map[i] = UNREACHED;
        head = 0;
        tail = 0;
        for (int gi = 0; gi < 4; gi++) begin
            cur = {(gi[0] ? GOAL_HI : GOAL_LO), (gi[1] ? GOAL_HI : GOAL_LO)};
            step_map[cur] = 8'd0;
            visit[tail] = cur;
            tail++;
        end
        while (head < tail) begin
            cur = visit[head];
            head++;
            nxt = (step_map[cur] >= MAX_STEP) ? MAX_STEP : step_map[cur] + 8'd1;
            for (int d = 0; d < 4; d++) begin
                if (wall_map[cur][d]) continue;
                open = neighbor_cell(cur, d[1:0], nb);
                if (open && step_map[nb] == UNREACHED) begin
                    step_map[nb] = nxt;
                    if (tail < CELLS) begin
                        visit[tail] = nb;
                        tail++;
                    end
                end
            end
        end
    endfunction

    function automatic t_reply predict_reply(input t_opcode op, input logic [3:0] x,
                                             input logic [3:0] y, input logic [3:0] walls,
                                             input logic [1:0] heading);
        t_reply     r;
        logic [7:0] idx;
        logic [7:0] nb;
        logic [7:0] best;
        bit         open;
        r = '0;
        idx = {y, x};
        if (op == OP_WRITE) begin
            if (on_grid(int'(x), int'(y))) wall_map[idx] = walls;
        end else if (op == OP_FLOOD) begin
            redo_distances();
            r.flood_done = 1'b1;
        end else if (!on_grid(int'(x), int'(y))) begin
            r.distance = UNREACHED;
            if (op == OP_DIR) r.move_dir = t_dir'(heading);
        end else if (op == OP_DIST) begin
            r.distance = step_map[idx];
        end else begin
            r.distance = step_map[idx];
            r.move_dir = t_dir'(heading);
            best = UNREACHED;
            for (int d = 0; d < 4; d++) begin
                if (wall_map[idx][d]) continue;
                open = neighbor_cell(idx, d[1:0], nb);
                if (open && step_map[nb] < best) begin
                    best = step_map[nb];
                    r.move_dir = t_dir'(d);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            foreach (wall_map[i]) wall_map[i] = 4'd0;
            foreach (step_map[i]) step_map[i] = UNREACHED;
            expected_replies.delete();
            fail_total = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_replies.push_back(predict_reply(t_opcode'(i_req.opcode),
                    i_req.cell_x, i_req.cell_y, i_req.wall_bits, i_req.heading));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.distance = i_rsp.distance;
                got.move_dir = t_dir'(i_rsp.move_dir);
                got.flood_done = i_rsp.flood_done;
                if (expected_replies.size() == 0) begin
                    $error("reply: none expected, got distance %0d move_dir %0d flood_done %0d",
                           got.distance, got.move_dir, got.flood_done);
                    fail_total++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d", want.distance,
                               got.distance);
                        fail_total++;
                    end
                    if (got.move_dir !== want.move_dir) begin
                        $error("move_dir: expected %0d, actual %0d", want.move_dir,
                               got.move_dir);
                        fail_total++;
                    end
                    if (got.flood_done !== want.flood_done) begin
                        $error("flood_done: expected %0d, actual %0d", want.flood_done,
                               got.flood_done);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_replies.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the flood-fill engine testbench: clock, reset, request stimulus and response pacing.
// Depends on mff_pkg, mff_if, maze_flood_fill_engine and flood_checker.
module tb_top;
    import mff_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_replies;
    int   requests_accepted = 0;
    int   stall_pct = 0;

    mff_req_if req_bus();
    mff_rsp_if rsp_bus();

    maze_flood_fill_engine dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    flood_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .i_rsp       (rsp_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending_replies)
    );

    always #2 i_clk = ~i_clk;

    task automatic offer_request(input t_opcode op, input logic [3:0] x, input logic [3:0] y,
                                 input logic [3:0] walls, input logic [1:0] heading);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.opcode <= op;
        req_bus.cell_x <= x;
        req_bus.cell_y <= y;
        req_bus.wall_bits <= walls;
        req_bus.heading <= heading;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        requests_accepted++;
    endtask

    function automatic logic [3:0] pick_walls();
        case ($urandom_range(0, 3))
            0:       return 4'd0;
            1:       return 4'd1 << $urandom_range(0, 3);
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic offer_query();
        offer_request($urandom_range(0, 1) ? OP_DIST : OP_DIR, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
    endtask

    initial begin : stimulus
        int total;
        int gap_row;
        int column;
        req_bus.valid <= 1'b0;
        req_bus.opcode <= OP_WRITE;
        req_bus.cell_x <= 4'd0;
        req_bus.cell_y <= 4'd0;
        req_bus.wall_bits <= 4'd0;
        req_bus.heading <= 2'd0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall_pct = 10;
        offer_request(OP_DIST, 4'd0, 4'd0, 4'd0, DIR_NORTH);
        for (int h = 0; h < 4; h++) offer_request(OP_DIR, 4'd15, 4'd15, 4'd15, 2'(h));
        offer_request(OP_WRITE, 4'd0, 4'd0, 4'hF, DIR_NORTH);
        offer_request(OP_WRITE, 4'd15, 4'd15, 4'h0, DIR_WEST);
        offer_request(OP_WRITE, 4'd15, 4'd0, 4'hA, DIR_EAST);
        offer_request(OP_WRITE, 4'd0, 4'd15, 4'h5, DIR_SOUTH);
        offer_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, DIR_NORTH);
        offer_request(OP_DIST, 4'd7, 4'd7, 4'd0, DIR_NORTH);
        offer_request(OP_DIST, 4'd0, 4'd0, 4'd0, DIR_NORTH);
        offer_request(OP_DIST, 4'd15, 4'd15, 4'd0, DIR_NORTH);
        offer_request(OP_DIR, 4'd0, 4'd0, 4'd0, DIR_SOUTH);
        offer_request(OP_DIR, 4'd15, 4'd15, 4'd0, DIR_EAST);
        offer_request(OP_DIR, 4'd8, 4'd8, 4'd0, DIR_WEST);
        offer_request(OP_DIR, 4'd0, 4'd15, 4'd0, DIR_NORTH);
        offer_request(OP_WRITE, 4'd8, 4'd8, 4'hF, DIR_NORTH);
        offer_request(OP_WRITE, 4'd7, 4'd8, 4'h3, DIR_NORTH);
        offer_request(OP_FLOOD, 4'd15, 4'd15, 4'hF, DIR_WEST);
        offer_request(OP_DIST, 4'd8, 4'd8, 4'd0, DIR_NORTH);
        offer_request(OP_DIR, 4'd15, 4'd0, 4'd0, DIR_WEST);
        offer_request(OP_DIR, 4'd7, 4'd9, 4'd0, DIR_SOUTH);

        total = requests_accepted + RANDOM_ITEMS;
        while (requests_accepted < total) begin
            if (requests_accepted >= total - CALM_ITEMS) begin
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    repeat ($urandom_range(2, 12)) begin
                        offer_request(OP_WRITE, 4'($urandom_range(0, 15)),
                                      4'($urandom_range(0, 15)), pick_walls(),
                                      2'($urandom_range(0, 3)));
                    end
                    offer_request(OP_FLOOD, 4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  2'($urandom_range(0, 3)));
                    repeat ($urandom_range(3, 10)) offer_query();
                end
                6, 7: begin
                    column = $urandom_range(0, 14);
                    gap_row = $urandom_range(0, 15);
                    for (int y = 0; y < GRID_SIDE; y++) begin
                        offer_request(OP_WRITE, 4'(column), 4'(y),
                                      (y == gap_row) ? 4'h0 : 4'h2, 2'($urandom_range(0, 3)));
                    end
                    offer_request(OP_FLOOD, 4'd0, 4'd0, 4'd0, DIR_NORTH);
                    repeat ($urandom_range(3, 8)) offer_query();
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        offer_request(t_opcode'($urandom_range(0, 3)),
                                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                      4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
                    end
                end
            endcase
        end
        req_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_replies != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : response_pacing
        bit held;
        held = 1'b0;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && requests_accepted >= HOLD_AT) begin
                held = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct / 3) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mff_pkg.sv
hdl/mff_if.sv
hdl/mff_cell_store.sv
hdl/mff_queue.sv
hdl/maze_flood_fill_engine.sv
bench/flood_checker.sv
bench/tb_top.sv
